@@ design/sete_pkg.sv @@
// Shared types, register indexes and helper functions for the sprite entry tile expander.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sete_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SCREEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_SIZES = 1'd1;

  localparam logic [1:0] PRIO_NONE = 2'd0;
  localparam logic [1:0] PRIO_LOW  = 2'd1;
  localparam logic [1:0] PRIO_MID  = 2'd2;
  localparam logic [1:0] PRIO_HIGH = 2'd3;

  localparam int ATTR_ENABLE_BIT = 2;

  typedef struct packed {
    logic [15:0] attr_word;
    logic [15:0] code_word;
    logic [15:0] size_color_word;
    logic [15:0] y_word;
    logic [15:0] x_word;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
    logic last_cell;
  } dp_sts_t;

  // Largest cell index along one axis for a log2 size.
  function automatic logic [2:0] size_max(input logic [1:0] lg);
    logic [2:0] m;
    case (lg)
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

  // Interleave column and row bits: x0, y0, x1, y1, x2, y2 from the lowest bit.
  function automatic logic [5:0] morton(input logic [2:0] cx, input logic [2:0] cy);
    return {cy[2], cx[2], cy[1], cx[1], cy[0], cx[0]};
  endfunction

endpackage

`default_nettype wire

@@ design/sete_ctrl.sv @@
// Controller state machine of the sprite entry tile expander.
// Depends on sete_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sete_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  input  wire                in_enable,
  input  wire                out_tready,
  input  sete_pkg::dp_sts_t  sts,
  output logic               in_tready,
  output sete_pkg::dp_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cmd.load  = (state_r == ST_IDLE) && in_tvalid && in_enable;
    cmd.step  = (state_r == ST_RUN) && (!sts.out_full || out_tready);
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && sts.last_cell) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last_cell) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after the last tile");

  a_enabled_entry_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_enable) |=> (state_r == ST_RUN))
    else $error("enabled entry did not start a run");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.out_full && !out_tready) |-> !cmd.step)
    else $error("tile issued into a full output register");

endmodule

`default_nettype wire

@@ design/sete_datapath.sv @@
// Datapath of the sprite entry tile expander: entry decode, cell counters and output register.
// Depends on sete_pkg for the entry type, command and status structs and helper functions.
`timescale 1ns / 1ps
`default_nettype none

module sete_datapath (
  input  wire                clk,
  input  wire                rst_n,
  input  sete_pkg::entry_t   entry,
  input  wire                flip_screen,
  input  wire                square_sizes,
  input  sete_pkg::dp_cmd_t  cmd,
  input  wire                out_tready,
  output sete_pkg::dp_sts_t  sts,
  output logic               out_valid,
  output logic [15:0]        tile_code,
  output logic [3:0]         tile_color,
  output logic               mirror_x,
  output logic               mirror_y,
  output logic signed [16:0] screen_x,
  output logic signed [16:0] screen_y,
  output logic [7:0]         layer_mask,
  output logic               last_tile
);

  logic [15:0]        code_r;
  logic [3:0]         color_r;
  logic               fx_r;
  logic               fy_r;
  logic [2:0]         wmax_r;
  logic [2:0]         hmax_r;
  logic signed [16:0] bx_r;
  logic signed [16:0] by_r;
  logic [7:0]         mask_r;
  logic [2:0]         col_r;
  logic [2:0]         row_r;

  logic               out_valid_r;
  logic [15:0]        tile_code_r;
  logic [3:0]         tile_color_r;
  logic               mirror_x_r;
  logic               mirror_y_r;
  logic signed [16:0] screen_x_r;
  logic signed [16:0] screen_y_r;
  logic [7:0]         layer_mask_r;
  logic               last_tile_r;

  logic [1:0]         lw;
  logic [1:0]         lh;
  logic [2:0]         wmax_nxt;
  logic [2:0]         hmax_nxt;
  logic signed [16:0] xs;
  logic signed [16:0] ys;
  logic [7:0]         mask_nxt;
  logic [2:0]         cx;
  logic [2:0]         cy;
  logic signed [16:0] offx;
  logic signed [16:0] offy;
  logic               last_cell;

  always_comb begin
    lw       = entry.size_color_word[1:0];
    lh       = square_sizes ? lw : entry.size_color_word[3:2];
    wmax_nxt = sete_pkg::size_max(lw);
    hmax_nxt = sete_pkg::size_max(lh);
    xs       = {entry.x_word[15], entry.x_word};
    ys       = {entry.y_word[15], entry.y_word};
    unique case (entry.attr_word[7:6])
      sete_pkg::PRIO_NONE: mask_nxt = 8'h00;
      sete_pkg::PRIO_LOW:  mask_nxt = 8'hf0;
      sete_pkg::PRIO_MID:  mask_nxt = 8'hfc;
      sete_pkg::PRIO_HIGH: mask_nxt = 8'hfe;
      default:             mask_nxt = 8'h00;
    endcase
  end

  always_comb begin
    cx        = col_r ^ (fx_r ? wmax_r : 3'd0);
    cy        = row_r ^ (fy_r ? hmax_r : 3'd0);
    offx      = {11'd0, cx, 3'd0};
    offy      = {11'd0, cy, 3'd0};
    last_cell = (col_r == wmax_r) && (row_r == hmax_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r  <= entry.code_word & ~{10'd0, sete_pkg::morton(wmax_nxt, hmax_nxt)};
      color_r <= entry.size_color_word[7:4];
      fx_r    <= entry.attr_word[0];
      fy_r    <= entry.attr_word[1];
      wmax_r  <= wmax_nxt;
      hmax_r  <= hmax_nxt;
      bx_r    <= flip_screen ? (17'sd248 - xs) : xs;
      by_r    <= flip_screen ? (17'sd248 - ys) : ys;
      mask_r  <= mask_nxt;
      col_r   <= 3'd0;
      row_r   <= 3'd0;
    end else if (cmd.step) begin
      if (col_r == wmax_r) begin
        col_r <= 3'd0;
        row_r <= row_r + 3'd1;
      end else begin
        col_r <= col_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      tile_code_r  <= code_r | {10'd0, sete_pkg::morton(col_r, row_r)};
      tile_color_r <= color_r;
      mirror_x_r   <= fx_r ^ flip_screen;
      mirror_y_r   <= fy_r ^ flip_screen;
      screen_x_r   <= flip_screen ? (bx_r - offx) : (bx_r + offx);
      screen_y_r   <= flip_screen ? (by_r - offy) : (by_r + offy);
      layer_mask_r <= mask_r;
      last_tile_r  <= last_cell;
    end
  end

  always_comb begin
    sts.out_full  = out_valid_r;
    sts.last_cell = last_cell;
    out_valid     = out_valid_r;
    tile_code     = tile_code_r;
    tile_color    = tile_color_r;
    mirror_x      = mirror_x_r;
    mirror_y      = mirror_y_r;
    screen_x      = screen_x_r;
    screen_y      = screen_y_r;
    layer_mask    = layer_mask_r;
    last_tile     = last_tile_r;
  end

  a_load_clears_cells: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (col_r == 3'd0) && (row_r == 3'd0))
    else $error("cell counters not cleared on a new entry");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid_r)
    else $error("issued tile did not reach the output register");

endmodule

`default_nettype wire

@@ design/sprite_entry_tile_expander_unit.sv @@
// Top level of the sprite entry tile expander: configuration registers and stream ports.
// Depends on sete_pkg, sete_ctrl and sete_datapath.
//
// One five-word sprite entry arrives per input word on the in_ channel. An entry
// with its enable bit clear is taken without a run and gives no output. An enabled
// entry of W by H tiles gives W*H tile words on the out_ channel, row by row, the
// final one marked by out_tlast; W and H are each 1, 2, 4 or 8, so up to 64 words.
// The cell counters step once per cycle while the output register can take a word;
// each step puts one tile word into the output register, built from the entry
// registers loaded when the entry was taken. A new entry is taken as soon as the
// previous one's last tile has entered the output register, even while that word waits.
// While the output register is full and out_tready is low, the word stays and the
// counters stop. Reset clears both configuration registers and empties the output
// register. The user must write configuration through cfg_we, cfg_addr and cfg_wdata
// only while the block is idle (not enforced); index 0 is flip_screen, 1 square_sizes.
`timescale 1ns / 1ps
`default_nettype none

module sprite_entry_tile_expander_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // attr_word, code_word, size_color_word, y_word, x_word
  input  wire  [79:0]                      in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // tile_code, tile_color, mirror_x, mirror_y, screen_x, screen_y, layer_mask
  output logic [63:0]                      out_tdata,
  output logic                             out_tlast,
  input  wire                              cfg_we,
  input  wire  [sete_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [0:0]                       cfg_wdata
);

  logic flip_screen_r;
  logic square_sizes_r;

  sete_pkg::entry_t  entry;
  sete_pkg::dp_cmd_t cmd;
  sete_pkg::dp_sts_t sts;

  logic [15:0]        tile_code;
  logic [3:0]         tile_color;
  logic               mirror_x;
  logic               mirror_y;
  logic signed [16:0] screen_x;
  logic signed [16:0] screen_y;
  logic [7:0]         layer_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_screen_r  <= 1'b0;
      square_sizes_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sete_pkg::CFG_FLIP_SCREEN:  flip_screen_r  <= cfg_wdata[0];
        sete_pkg::CFG_SQUARE_SIZES: square_sizes_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    entry.attr_word       = in_tdata[15:0];
    entry.code_word       = in_tdata[31:16];
    entry.size_color_word = in_tdata[47:32];
    entry.y_word          = in_tdata[63:48];
    entry.x_word          = in_tdata[79:64];
  end

  sete_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_enable  (entry.attr_word[sete_pkg::ATTR_ENABLE_BIT]),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  sete_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry        (entry),
    .flip_screen  (flip_screen_r),
    .square_sizes (square_sizes_r),
    .cmd          (cmd),
    .out_tready   (out_tready),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .tile_code    (tile_code),
    .tile_color   (tile_color),
    .mirror_x     (mirror_x),
    .mirror_y     (mirror_y),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .layer_mask   (layer_mask),
    .last_tile    (out_tlast)
  );

  assign out_tdata = {layer_mask, screen_y, screen_x, mirror_y, mirror_x, tile_color, tile_code};

endmodule

`default_nettype wire

@@ tb/sprite_entry_tile_expander_unit_tb.sv @@
// Self-checking testbench for sprite_entry_tile_expander_unit: sends sprite entries,
// predicts every tile word and compares each output word field by field.
// Depends on sete_pkg and the design files under design/.
`timescale 1ns / 1ps

module sprite_entry_tile_expander_unit_tb;

  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 160;

  typedef struct packed {
    logic [15:0] code;
    logic [3:0]  color;
    logic        mirror_x;
    logic        mirror_y;
    logic [16:0] sx;
    logic [16:0] sy;
    logic [7:0]  layers;
    logic        last;
  } tile_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [sete_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [0:0]  cfg_wdata = '0;

  tile_word_t pending_tiles[$];
  int  mismatches = 0;
  bit  flip_screen_q = 1'b0;
  bit  square_sizes_q = 1'b0;
  bit  quiet_in = 1'b0;
  bit  quiet_out = 1'b0;
  int  hold_asked = 0;
  int  hold_done = 0;
  int  hold_left = 0;

  sprite_entry_tile_expander_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic sete_pkg::entry_t make_entry(input logic [15:0] attr,
                                                  input logic [15:0] code,
                                                  input logic [15:0] szc,
                                                  input logic [15:0] ypos,
                                                  input logic [15:0] xpos);
    sete_pkg::entry_t e;
    e.attr_word = attr;
    e.code_word = code;
    e.size_color_word = szc;
    e.y_word = ypos;
    e.x_word = xpos;
    return e;
  endfunction

  // Expands one accepted entry into the tile words it must produce.
  task automatic expand_entry(input sete_pkg::entry_t e);
    tile_word_t t;
    logic [1:0]  lw, lh;
    logic [15:0] base;
    logic [5:0]  offset;
    int w, h, xpos, ypos, cx, cy, sx, sy;
    if (!e.attr_word[sete_pkg::ATTR_ENABLE_BIT]) return;
    lw = e.size_color_word[1:0];
    lh = square_sizes_q ? lw : e.size_color_word[3:2];
    w = 1 << lw;
    h = 1 << lh;
    base = e.code_word;
    for (int b = 0; b < 3; b++) begin
      if (lw > b) base[2*b] = 1'b0;
      if (lh > b) base[2*b+1] = 1'b0;
    end
    xpos = int'($signed(e.x_word));
    ypos = int'($signed(e.y_word));
    for (int row = 0; row < h; row++) begin
      for (int col = 0; col < w; col++) begin
        offset = '0;
        for (int b = 0; b < 3; b++) begin
          offset[2*b] = col[b];
          offset[2*b+1] = row[b];
        end
        cx = e.attr_word[0] ? (w - 1 - col) : col;
        cy = e.attr_word[1] ? (h - 1 - row) : row;
        if (flip_screen_q) begin
          sx = 248 - xpos - 8 * cx;
          sy = 248 - ypos - 8 * cy;
        end else begin
          sx = xpos + 8 * cx;
          sy = ypos + 8 * cy;
        end
        t.code = base + {10'd0, offset};
        t.color = e.size_color_word[7:4];
        t.mirror_x = e.attr_word[0] ^ flip_screen_q;
        t.mirror_y = e.attr_word[1] ^ flip_screen_q;
        t.sx = sx[16:0];
        t.sy = sy[16:0];
        case (e.attr_word[7:6])
          sete_pkg::PRIO_LOW:  t.layers = 8'hf0;
          sete_pkg::PRIO_MID:  t.layers = 8'hfc;
          sete_pkg::PRIO_HIGH: t.layers = 8'hfe;
          default:             t.layers = 8'h00;
        endcase
        t.last = (row == h - 1) && (col == w - 1);
        pending_tiles.push_back(t);
      end
    end
  endtask

  task automatic send_entry(input sete_pkg::entry_t e);
    while (!quiet_in && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {e.x_word, e.y_word, e.size_color_word, e.code_word, e.attr_word};
    do @(posedge clk); while (!in_tready);
    expand_entry(e);
  endtask

  task automatic wait_for_tiles();
    in_tvalid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input bit flip_screen, input bit square_sizes);
    cfg_we <= 1'b1;
    cfg_addr <= sete_pkg::CFG_FLIP_SCREEN;
    cfg_wdata <= flip_screen;
    @(posedge clk);
    cfg_addr <= sete_pkg::CFG_SQUARE_SIZES;
    cfg_wdata <= square_sizes;
    @(posedge clk);
    cfg_we <= 1'b0;
    flip_screen_q = flip_screen;
    square_sizes_q = square_sizes;
  endtask

  function automatic sete_pkg::entry_t random_entry();
    sete_pkg::entry_t e;
    e.attr_word = 16'($urandom);
    e.attr_word[sete_pkg::ATTR_ENABLE_BIT] = ($urandom_range(99) < 85);
    e.code_word = 16'($urandom);
    e.size_color_word = 16'($urandom);
    e.size_color_word[1:0] = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    e.size_color_word[3:2] = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    e.y_word = 16'($urandom);
    e.x_word = 16'($urandom);
    return e;
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      out_tready <= quiet_out || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    tile_word_t t;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tiles.size() == 0) begin
        report_mismatch("unexpected tile word", out_tdata[31:0], 32'd0);
      end else begin
        t = pending_tiles.pop_front();
        if (out_tdata[15:0] !== t.code)
          report_mismatch("tile_code", 32'(out_tdata[15:0]), 32'(t.code));
        if (out_tdata[19:16] !== t.color)
          report_mismatch("tile_color", 32'(out_tdata[19:16]), 32'(t.color));
        if (out_tdata[20] !== t.mirror_x)
          report_mismatch("mirror_x", 32'(out_tdata[20]), 32'(t.mirror_x));
        if (out_tdata[21] !== t.mirror_y)
          report_mismatch("mirror_y", 32'(out_tdata[21]), 32'(t.mirror_y));
        if (out_tdata[38:22] !== t.sx)
          report_mismatch("screen_x", 32'(out_tdata[38:22]), 32'(t.sx));
        if (out_tdata[55:39] !== t.sy)
          report_mismatch("screen_y", 32'(out_tdata[55:39]), 32'(t.sy));
        if (out_tdata[63:56] !== t.layers)
          report_mismatch("layer_mask", 32'(out_tdata[63:56]), 32'(t.layers));
        if (out_tlast !== t.last)
          report_mismatch("last_tile", 32'(out_tlast), 32'(t.last));
      end
    end
  end

  task automatic test_directed_shapes();
    write_regs(1'b0, 1'b0);
    send_entry(make_entry(16'hfffb, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_entry(make_entry(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(make_entry(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(make_entry(16'h00c7, 16'hffff, 16'h00ff, 16'h7fff, 16'h8000));
    send_entry(make_entry(16'h0044, 16'haaaa, 16'h000c, 16'h8000, 16'h7fff));
    send_entry(make_entry(16'h0085, 16'h5555, 16'h0013, 16'hffff, 16'h0000));
    send_entry(make_entry(16'h0006, 16'h0fff, 16'h0029, 16'h0000, 16'hffff));
    send_entry(make_entry(16'hff3f, 16'hf00f, 16'hff36, 16'h0100, 16'hff00));
    wait_for_tiles();
  endtask

  task automatic test_square_sizes();
    write_regs(1'b0, 1'b1);
    send_entry(make_entry(16'h0044, 16'hffff, 16'h0003, 16'h0010, 16'h0020));
    send_entry(make_entry(16'h0087, 16'h1234, 16'h00ad, 16'hfff0, 16'h8000));
    send_entry(make_entry(16'h00c5, 16'hffff, 16'h00c6, 16'h7fff, 16'h7fff));
    send_entry(make_entry(16'h0006, 16'h00ff, 16'h001c, 16'h0000, 16'h0000));
    wait_for_tiles();
  endtask

  task automatic test_flip_screen();
    write_regs(1'b1, 1'b0);
    send_entry(make_entry(16'h00c5, 16'hffff, 16'h00ff, 16'h8000, 16'h7fff));
    send_entry(make_entry(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_entry(make_entry(16'h0047, 16'h8001, 16'h0029, 16'h7fff, 16'hffff));
    send_entry(make_entry(16'h0086, 16'h7ffe, 16'h0016, 16'hffff, 16'h8000));
    wait_for_tiles();
    write_regs(1'b1, 1'b1);
    send_entry(make_entry(16'h00c7, 16'hffff, 16'h00f3, 16'h7fff, 16'h8000));
    send_entry(make_entry(16'h0005, 16'h0003, 16'h000d, 16'h0100, 16'h00f8));
    wait_for_tiles();
  endtask

  // The receiver holds off while the sender keeps offering large entries.
  task automatic test_output_stall();
    write_regs(1'b0, 1'b0);
    hold_asked++;
    repeat (5) begin
      send_entry(make_entry(16'h00c4 | 16'($urandom_range(3)), 16'($urandom),
                            16'h00ff, 16'($urandom), 16'($urandom)));
    end
    wait_for_tiles();
  endtask

  task automatic test_random_entries();
    for (int phase = 0; phase < 4; phase++) begin
      write_regs(phase[0], phase[1]);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        quiet_in = (phase == 2) && (n < 30);
        quiet_out = quiet_in;
        send_entry(random_entry());
        if ($urandom_range(29) == 0) wait_for_tiles();
      end
      quiet_in = 1'b0;
      quiet_out = 1'b0;
      wait_for_tiles();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_square_sizes();
    test_flip_screen();
    test_output_stall();
    test_random_entries();
    wait_for_tiles();
    if (mismatches == 0) begin
      $display("sprite_entry_tile_expander_unit_tb: PASS");
    end else begin
      $display("sprite_entry_tile_expander_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d tile words outstanding", pending_tiles.size());
    $display("sprite_entry_tile_expander_unit_tb: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sete_pkg.sv
design/sete_ctrl.sv
design/sete_datapath.sv
design/sprite_entry_tile_expander_unit.sv
tb/sprite_entry_tile_expander_unit_tb.sv
